/* hw/rtl/hqr_pkg.sv */
// Shared types, constants and saturation helper for the Householder QR unit.
package hqr_pkg;

   localparam int WORD_W        = 32;
   localparam int ACC_W         = 64;
   localparam int MAX_DIM_DEF   = 8;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DIM_REG_W     = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int OPCODE_W      = 2;
   localparam int INDEX_W       = 3;
   localparam int STATUS_W      = 2;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHAPE_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_DECOMP = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED    = 2'd3;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_START  = 2'd1,
      OP_READ_Q = 2'd2,
      OP_READ_R = 2'd3
   } opcode_type;

   // Saturates a wide signed value to one 32-bit word.
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [WORD_W-1:0] r;
      if (x > 64'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (x < 64'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = x[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/hqr_ram.sv */
// Generic RAM with one write port and two registered read ports.
module hqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

/* hw/rtl/hqr_div.sv */
// Iterative restoring divider for signed fixed-point quotients with saturation.
module hqr_div #(
   parameter int FRAC_BITS = hqr_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [hqr_pkg::WORD_W-1:0]      num,
   input  logic signed [hqr_pkg::WORD_W-1:0]      den,
   output logic                                   done,
   output logic signed [hqr_pkg::WORD_W-1:0]      quot
);

   localparam int NUM_W = hqr_pkg::WORD_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [NUM_W-1:0]           sh_ff, sh_in;
   logic [NUM_W-1:0]           quo_ff, quo_in;
   logic [hqr_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [hqr_pkg::WORD_W-1:0] dm_ff, dm_in;
   logic                       neg_ff, neg_in;
   logic signed [hqr_pkg::WORD_W-1:0] res_ff, res_in;

   logic [hqr_pkg::WORD_W-1:0] num_mag, den_mag;
   logic [hqr_pkg::WORD_W:0]   rem_x;
   logic                       ge;
   logic                       big;

   assign num_mag = num[hqr_pkg::WORD_W-1] ? (~num + hqr_pkg::WORD_W'(1)) : num;
   assign den_mag = den[hqr_pkg::WORD_W-1] ? (~den + hqr_pkg::WORD_W'(1)) : den;
   assign rem_x   = {rem_ff, sh_ff[NUM_W-1]};
   assign ge      = rem_x >= {1'b0, dm_ff};
   assign big     = |quo_in[NUM_W-1:hqr_pkg::WORD_W-1];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (start) begin
         neg_in = num[hqr_pkg::WORD_W-1] != den[hqr_pkg::WORD_W-1];
         dm_in  = den_mag;
         if (den_mag == '0) begin
            done_in = 1'b1;
            if (num == '0) begin
               res_in = '0;
            end else if (num[hqr_pkg::WORD_W-1]) begin
               res_in = hqr_pkg::WORD_MIN;
            end else begin
               res_in = hqr_pkg::WORD_MAX;
            end
         end else begin
            run_in = 1'b1;
            sh_in  = {num_mag, {FRAC_BITS{1'b0}}};
            rem_in = '0;
            quo_in = '0;
            cnt_in = CNT_W'(NUM_W);
         end
      end else if (run_ff) begin
         rem_in = ge ? rem_x[hqr_pkg::WORD_W-1:0] - dm_ff : rem_x[hqr_pkg::WORD_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         sh_in  = {sh_ff[NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            // Quotients of 2^31 and above saturate to the limit of the result sign.
            if (big) begin
               res_in = neg_ff ? hqr_pkg::WORD_MIN : hqr_pkg::WORD_MAX;
            end else if (neg_ff) begin
               res_in = -$signed(quo_in[hqr_pkg::WORD_W-1:0]);
            end else begin
               res_in = $signed(quo_in[hqr_pkg::WORD_W-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign quot = res_ff;

endmodule

/* hw/rtl/hqr_sqrt.sv */
// Bit-serial floor square root of a fixed-point word, one result bit per step.
module hqr_sqrt #(
   parameter int FRAC_BITS = hqr_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [hqr_pkg::WORD_W-1:0] x,
   output logic                              done,
   output logic signed [hqr_pkg::WORD_W-1:0] root
);

   localparam int STEPS = 32;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [hqr_pkg::ACC_W-1:0] BIT_INIT = 64'd1 << 62;

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [hqr_pkg::ACC_W-1:0]  v_ff, v_in;
   logic [hqr_pkg::ACC_W-1:0]  res_ff, res_in;
   logic [hqr_pkg::ACC_W-1:0]  bit_ff, bit_in;
   logic [hqr_pkg::ACC_W-1:0]  trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         res_in = '0;
         if (x <= 0) begin
            done_in = 1'b1;
         end else begin
            run_in = 1'b1;
            v_in   = hqr_pkg::ACC_W'(x) << FRAC_BITS;
            bit_in = BIT_INIT;
            cnt_in = CNT_W'(STEPS);
         end
      end else if (run_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = $signed(res_ff[hqr_pkg::WORD_W-1:0]);

endmodule

/* hw/rtl/householder_qr_decomposition_unit.sv */
// Top level of the Householder QR unit: command port, sequencer, shared multiplier.
// Element writes give no result; reads give their result in the cycle after the
// transfer, and both are accepted back to back while busy is low.
// A start keeps busy high through the divisions, square roots and multiply loops.
// Reset is synchronous: status clears, dimensions return to 8, the stores keep contents.
module householder_qr_decomposition_unit #(
   parameter int MAX_DIM   = hqr_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = hqr_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [hqr_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [hqr_pkg::INDEX_W-1:0]          req_row,
   input  logic [hqr_pkg::INDEX_W-1:0]          req_col,
   input  logic signed [hqr_pkg::WORD_W-1:0]    req_value,
   output logic                                 rsp_valid,
   output logic signed [hqr_pkg::WORD_W-1:0]    rsp_result_value,
   output logic [hqr_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hqr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hqr_pkg::DIM_REG_W-1:0]        csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int W      = hqr_pkg::WORD_W;
   localparam int AW     = hqr_pkg::ACC_W;
   localparam logic signed [W-1:0]  ONE  = W'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

   typedef enum logic [30:0] {
      ST_IDLE    = 31'(1) << 0,
      ST_CHK     = 31'(1) << 1,
      ST_QINIT   = 31'(1) << 2,
      ST_MAX_RD  = 31'(1) << 3,
      ST_MAX_AC  = 31'(1) << 4,
      ST_NRM_RD  = 31'(1) << 5,
      ST_NRM_DIV = 31'(1) << 6,
      ST_NRM_DW  = 31'(1) << 7,
      ST_NRM_ACC = 31'(1) << 8,
      ST_AKK_RD  = 31'(1) << 9,
      ST_AKK     = 31'(1) << 10,
      ST_SQ1     = 31'(1) << 11,
      ST_AL      = 31'(1) << 12,
      ST_W_MUL   = 31'(1) << 13,
      ST_W       = 31'(1) << 14,
      ST_SQ2     = 31'(1) << 15,
      ST_VKK     = 31'(1) << 16,
      ST_V_RD    = 31'(1) << 17,
      ST_V_DIV   = 31'(1) << 18,
      ST_V_W     = 31'(1) << 19,
      ST_UD_RD   = 31'(1) << 20,
      ST_UD_MUL  = 31'(1) << 21,
      ST_UD_ACC  = 31'(1) << 22,
      ST_UU_RD   = 31'(1) << 23,
      ST_UU_MUL  = 31'(1) << 24,
      ST_UU_WR   = 31'(1) << 25,
      ST_FIN_K   = 31'(1) << 26,
      ST_ZERO    = 31'(1) << 27,
      ST_NEXTK   = 31'(1) << 28,
      ST_DONE    = 31'(1) << 29,
      ST_SPARE   = 31'(1) << 30
   } state_type;

   function automatic logic [ADDR_W-1:0] mk_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [hqr_pkg::DIM_REG_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = CNT_W'(MAX_DIM);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [hqr_pkg::DIM_REG_W-1:0] row_count_ff, row_count_in;
   logic [hqr_pkg::DIM_REG_W-1:0] col_count_ff, col_count_in;
   logic [hqr_pkg::STATUS_W-1:0]  last_status_ff, last_status_in;
   logic rd_pend_ff, rd_pend_in;
   logic rd_q_ff, rd_q_in;
   logic rd_ok_ff, rd_ok_in;
   logic upd_q_ff, upd_q_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, jj_ff, jj_in, k_ff, k_in;
   logic signed [W-1:0] u_ff, u_in, akk_ff, akk_in, alpha_ff, alpha_in;
   logic signed [W-1:0] w_ff, w_in, t_ff, t_in, x_ff, x_in;
   logic signed [AW-1:0] acc_ff, acc_in, prod_ff;

   logic [CNT_W-1:0] m_eff, n_eff, nn_eff;
   logic i_last, j_last_m;
   logic host_ok, accept;
   logic [ADDR_W-1:0] host_addr, alg_addr_a, addr_a, a_addr_b, q_addr_b;
   logic a_we, q_we;
   logic [ADDR_W-1:0] a_waddr, q_waddr;
   logic signed [W-1:0] a_wdata, q_wdata;
   logic signed [W-1:0] a_rd_a, a_rd_b, q_rd_a, q_rd_b, b_data;
   logic signed [W-1:0] mul_a, mul_b, mag_clamp, diff_ak, diff_ka, upd_val;
   logic signed [AW-1:0] qmul_val, acc_sum;
   logic div_start, div_done, sqrt_start, sqrt_done;
   logic signed [W-1:0] div_n, div_d, div_quot, sqrt_x, sqrt_res;

   assign m_eff    = clamp_dim(row_count_ff);
   assign n_eff    = clamp_dim(col_count_ff);
   assign nn_eff   = (m_eff == n_eff) ? m_eff - CNT_W'(1) : n_eff;
   assign i_last   = i_ff == m_eff - CNT_W'(1);
   assign j_last_m = j_ff == m_eff - CNT_W'(1);

   assign accept    = start && !busy;
   assign host_ok   = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign host_addr = mk_addr(CNT_W'(req_row), CNT_W'(req_col));
   assign addr_a    = (state_ff == ST_IDLE) ? host_addr : alg_addr_a;

   // Rounded fixed-point product, taken from the registered full product.
   assign qmul_val  = (prod_ff + HALF) >>> FRAC_BITS;
   assign acc_sum   = acc_ff + qmul_val;
   assign b_data    = upd_q_ff ? q_rd_b : a_rd_b;
   assign mag_clamp = !a_rd_a[W-1] ? a_rd_a :
                      (a_rd_a == hqr_pkg::WORD_MIN) ? hqr_pkg::WORD_MAX : -a_rd_a;
   assign diff_ak   = hqr_pkg::sat32(AW'(alpha_ff) - AW'(akk_ff));
   assign diff_ka   = hqr_pkg::sat32(AW'(akk_ff) - AW'(alpha_ff));
   assign upd_val   = hqr_pkg::sat32(AW'(x_ff) - (qmul_val <<< 1));

   always_comb begin
      state_in       = state_ff;
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      last_status_in = last_status_ff;
      rd_pend_in     = 1'b0;
      rd_q_in        = rd_q_ff;
      rd_ok_in       = rd_ok_ff;
      upd_q_in       = upd_q_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      jj_in          = jj_ff;
      k_in           = k_ff;
      u_in           = u_ff;
      akk_in         = akk_ff;
      alpha_in       = alpha_ff;
      w_in           = w_ff;
      t_in           = t_ff;
      x_in           = x_ff;
      acc_in         = acc_ff;
      a_we           = 1'b0;
      a_waddr        = '0;
      a_wdata        = '0;
      q_we           = 1'b0;
      q_waddr        = '0;
      q_wdata        = '0;
      alg_addr_a     = '0;
      a_addr_b       = '0;
      q_addr_b       = '0;
      mul_a          = '0;
      mul_b          = '0;
      div_start      = 1'b0;
      div_n          = '0;
      div_d          = '0;
      sqrt_start     = 1'b0;
      sqrt_x         = '0;

      if (csr_valid) begin
         if (csr_index == hqr_pkg::CSR_ROW_COUNT) begin
            row_count_in = csr_wdata;
         end else begin
            col_count_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (hqr_pkg::opcode_type'(req_opcode))
                  hqr_pkg::OP_WRITE: begin
                     a_we    = host_ok;
                     a_waddr = host_addr;
                     a_wdata = req_value;
                  end
                  hqr_pkg::OP_START: begin
                     state_in = ST_CHK;
                  end
                  default: begin
                     rd_pend_in = 1'b1;
                     rd_q_in    = hqr_pkg::opcode_type'(req_opcode) == hqr_pkg::OP_READ_Q;
                     rd_ok_in   = host_ok;
                  end
               endcase
            end
         end
         ST_CHK: begin
            if (m_eff < n_eff) begin
               last_status_in = hqr_pkg::STATUS_SHAPE_ERR;
               state_in       = ST_DONE;
            end else begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_QINIT;
            end
         end
         ST_QINIT: begin
            q_we    = 1'b1;
            q_waddr = mk_addr(i_ff, j_ff);
            q_wdata = (i_ff == j_ff) ? ONE : '0;
            if (j_last_m) begin
               j_in = '0;
               i_in = i_ff + CNT_W'(1);
               if (i_last) begin
                  k_in = '0;
                  i_in = '0;
                  u_in = '0;
                  if (nn_eff == '0) begin
                     last_status_in = hqr_pkg::STATUS_OK;
                     state_in       = ST_DONE;
                  end else begin
                     state_in = ST_MAX_RD;
                  end
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         ST_MAX_RD: begin
            alg_addr_a = mk_addr(i_ff, k_ff);
            state_in   = ST_MAX_AC;
         end
         ST_MAX_AC: begin
            if (mag_clamp > u_ff) begin
               u_in = mag_clamp;
            end
            if (i_last) begin
               i_in     = k_ff;
               acc_in   = '0;
               state_in = ST_NRM_RD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_MAX_RD;
            end
         end
         ST_NRM_RD: begin
            alg_addr_a = mk_addr(i_ff, k_ff);
            state_in   = ST_NRM_DIV;
         end
         ST_NRM_DIV: begin
            div_start = 1'b1;
            div_n     = a_rd_a;
            div_d     = u_ff;
            state_in  = ST_NRM_DW;
         end
         ST_NRM_DW: begin
            mul_a = div_quot;
            mul_b = div_quot;
            if (div_done) begin
               state_in = ST_NRM_ACC;
            end
         end
         ST_NRM_ACC: begin
            acc_in = acc_sum;
            if (i_last) begin
               state_in = ST_AKK_RD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_NRM_RD;
            end
         end
         ST_AKK_RD: begin
            alg_addr_a = mk_addr(k_ff, k_ff);
            state_in   = ST_AKK;
         end
         ST_AKK: begin
            akk_in = a_rd_a;
            if (a_rd_a > 0) begin
               u_in = -u_ff;
            end
            sqrt_start = 1'b1;
            sqrt_x     = hqr_pkg::sat32(acc_ff);
            state_in   = ST_SQ1;
         end
         ST_SQ1: begin
            mul_a = u_ff;
            mul_b = sqrt_res;
            if (sqrt_done) begin
               state_in = ST_AL;
            end
         end
         ST_AL: begin
            alpha_in = hqr_pkg::sat32(qmul_val);
            if (hqr_pkg::sat32(qmul_val) == '0) begin
               last_status_in = hqr_pkg::STATUS_NOT_DECOMP;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            mul_a    = alpha_ff;
            mul_b    = diff_ak;
            state_in = ST_W;
         end
         ST_W: begin
            sqrt_start = 1'b1;
            sqrt_x     = hqr_pkg::sat32(qmul_val <<< 1);
            state_in   = ST_SQ2;
         end
         ST_SQ2: begin
            if (sqrt_done) begin
               w_in = sqrt_res;
               // A vanishing reflection leaves the column as it is.
               if (sqrt_res == '0) begin
                  state_in = ST_NEXTK;
               end else begin
                  div_start = 1'b1;
                  div_n     = diff_ka;
                  div_d     = sqrt_res;
                  state_in  = ST_VKK;
               end
            end
         end
         ST_VKK: begin
            if (div_done) begin
               a_we     = 1'b1;
               a_waddr  = mk_addr(k_ff, k_ff);
               a_wdata  = div_quot;
               i_in     = k_ff + CNT_W'(1);
               state_in = ST_V_RD;
            end
         end
         ST_V_RD: begin
            alg_addr_a = mk_addr(i_ff, k_ff);
            state_in   = ST_V_DIV;
         end
         ST_V_DIV: begin
            div_start = 1'b1;
            div_n     = a_rd_a;
            div_d     = w_ff;
            state_in  = ST_V_W;
         end
         ST_V_W: begin
            if (div_done) begin
               a_we    = 1'b1;
               a_waddr = mk_addr(i_ff, k_ff);
               a_wdata = div_quot;
               if (i_last) begin
                  upd_q_in = 1'b1;
                  j_in     = '0;
                  jj_in    = k_ff;
                  acc_in   = '0;
                  state_in = ST_UD_RD;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_V_RD;
               end
            end
         end
         ST_UD_RD: begin
            alg_addr_a = mk_addr(jj_ff, k_ff);
            q_addr_b   = mk_addr(j_ff, jj_ff);
            a_addr_b   = mk_addr(jj_ff, j_ff);
            state_in   = ST_UD_MUL;
         end
         ST_UD_MUL: begin
            mul_a    = a_rd_a;
            mul_b    = b_data;
            state_in = ST_UD_ACC;
         end
         ST_UD_ACC: begin
            acc_in = acc_sum;
            if (jj_ff == m_eff - CNT_W'(1)) begin
               t_in     = hqr_pkg::sat32(acc_sum);
               i_in     = k_ff;
               state_in = ST_UU_RD;
            end else begin
               jj_in    = jj_ff + CNT_W'(1);
               state_in = ST_UD_RD;
            end
         end
         ST_UU_RD: begin
            alg_addr_a = mk_addr(i_ff, k_ff);
            q_addr_b   = mk_addr(j_ff, i_ff);
            a_addr_b   = mk_addr(i_ff, j_ff);
            state_in   = ST_UU_MUL;
         end
         ST_UU_MUL: begin
            mul_a    = t_ff;
            mul_b    = a_rd_a;
            x_in     = b_data;
            state_in = ST_UU_WR;
         end
         ST_UU_WR: begin
            if (upd_q_ff) begin
               q_we    = 1'b1;
               q_waddr = mk_addr(j_ff, i_ff);
               q_wdata = upd_val;
            end else begin
               a_we    = 1'b1;
               a_waddr = mk_addr(i_ff, j_ff);
               a_wdata = upd_val;
            end
            if (!i_last) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_UU_RD;
            end else begin
               jj_in  = k_ff;
               acc_in = '0;
               j_in   = j_ff + CNT_W'(1);
               state_in = ST_UD_RD;
               if (upd_q_ff && j_last_m) begin
                  // Q is done; the remaining columns of R, if any, follow.
                  if (k_ff + CNT_W'(1) < n_eff) begin
                     upd_q_in = 1'b0;
                     j_in     = k_ff + CNT_W'(1);
                  end else begin
                     state_in = ST_FIN_K;
                  end
               end else if (!upd_q_ff && (j_ff == n_eff - CNT_W'(1))) begin
                  state_in = ST_FIN_K;
               end
            end
         end
         ST_FIN_K: begin
            a_we     = 1'b1;
            a_waddr  = mk_addr(k_ff, k_ff);
            a_wdata  = alpha_ff;
            i_in     = k_ff + CNT_W'(1);
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            a_we    = 1'b1;
            a_waddr = mk_addr(i_ff, k_ff);
            a_wdata = '0;
            if (i_last) begin
               state_in = ST_NEXTK;
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ST_NEXTK: begin
            if (k_ff == nn_eff - CNT_W'(1)) begin
               last_status_in = hqr_pkg::STATUS_OK;
               state_in       = ST_DONE;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               i_in     = k_ff + CNT_W'(1);
               u_in     = '0;
               state_in = ST_MAX_RD;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_count_ff   <= hqr_pkg::DIM_RESET;
         col_count_ff   <= hqr_pkg::DIM_RESET;
         last_status_ff <= hqr_pkg::STATUS_OK;
         rd_pend_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         last_status_ff <= last_status_in;
         rd_pend_ff     <= rd_pend_in;
      end
      rd_q_ff  <= rd_q_in;
      rd_ok_ff <= rd_ok_in;
      upd_q_ff <= upd_q_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      jj_ff    <= jj_in;
      k_ff     <= k_in;
      u_ff     <= u_in;
      akk_ff   <= akk_in;
      alpha_ff <= alpha_in;
      w_ff     <= w_in;
      t_ff     <= t_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      prod_ff  <= mul_a * mul_b;
   end

   hqr_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_a_ram (
      .clock     (clock),
      .wr_en     (a_we),
      .wr_addr   (a_waddr),
      .wr_data   (a_wdata),
      .rd_addr_a (addr_a),
      .rd_data_a (a_rd_a),
      .rd_addr_b (a_addr_b),
      .rd_data_b (a_rd_b)
   );

   hqr_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_q_ram (
      .clock     (clock),
      .wr_en     (q_we),
      .wr_addr   (q_waddr),
      .wr_data   (q_wdata),
      .rd_addr_a (addr_a),
      .rd_data_a (q_rd_a),
      .rd_addr_b (q_addr_b),
      .rd_data_b (q_rd_b)
   );

   hqr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_n),
      .den   (div_d),
      .done  (div_done),
      .quot  (div_quot)
   );

   hqr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .x     (sqrt_x),
      .done  (sqrt_done),
      .root  (sqrt_res)
   );

   assign busy             = state_ff != ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rd_pend_ff || (state_ff == ST_DONE);
   assign rsp_status       = last_status_ff;
   assign rsp_result_value = (rd_pend_ff && rd_ok_ff) ? (rd_q_ff ? q_rd_a : a_rd_a) : '0;

endmodule

/* hw/rtl/hqr_checker.sv */
// Port-level checks for the Householder QR unit, bound to the top level.
module hqr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [hqr_pkg::OPCODE_W-1:0]     req_opcode,
   input logic                             rsp_valid,
   input logic [hqr_pkg::STATUS_W-1:0]     rsp_status
);

   logic transfer;
   assign transfer = start && !busy;

   // An element write never produces a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      transfer && (req_opcode == hqr_pkg::OP_WRITE) |=> !rsp_valid)
      else $error("result after element write");

   // A read answers in the following cycle.
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      transfer && ((req_opcode == hqr_pkg::OP_READ_Q) || (req_opcode == hqr_pkg::OP_READ_R))
      |=> rsp_valid)
      else $error("read without result");

   // A start holds the unit busy, with no result, in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      transfer && (req_opcode == hqr_pkg::OP_START) |=> busy && !rsp_valid)
      else $error("start did not occupy the unit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != hqr_pkg::STATUS_UNUSED)
      else $error("undefined status code");

endmodule

bind householder_qr_decomposition_unit hqr_checker u_hqr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);

/* tb/sv/householder_qr_decomposition_unit_tb.sv */
// Testbench for the Householder QR unit: command stimulus, predicting scoreboard, result checks.
`timescale 1ns / 100ps

class qr_scoreboard;
   int a_word [64];
   int q_word [64];
   logic [1:0] status;
   int row_reg;
   int col_reg;
   int expected_value [$];
   logic [1:0] expected_status [$];
   int errors;

   function new();
      foreach (a_word[i]) begin
         a_word[i] = 0;
         q_word[i] = 0;
      end
      status = hqr_pkg::STATUS_OK;
      row_reg = 8;
      col_reg = 8;
      errors = 0;
   endfunction

   function int clip(longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return int'(x);
   endfunction

   // Rounded Q16.16 product; the arithmetic shift floors, so the bias gives ties upward.
   function longint qmul(int x, int y);
      longint p;
      p = longint'(x) * longint'(y);
      return (p + 64'sd32768) >>> 16;
   endfunction

   function longint magnitude(int x);
      return (x < 0) ? -longint'(x) : longint'(x);
   endfunction

   function int qdiv(int num, int den);
      longint nm, dm, q;
      nm = magnitude(num);
      dm = magnitude(den);
      if (dm == 0) begin
         if (num == 0) return 0;
         return (num > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      q = (nm << 16) / dm;
      if ((num < 0) != (den < 0)) begin
         if (q >= 64'sh8000_0000) return 32'h8000_0000;
         return int'(-q);
      end
      if (q > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      return int'(q);
   endfunction

   function int qsqrt(int x);
      longint unsigned v, res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      if (x <= 0) return 0;
      v = longint'(x) << 16;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return int'(res);
   endfunction

   function int dim(int v);
      if (v < 1) return 1;
      if (v > 8) return 8;
      return v;
   endfunction

   function logic [1:0] factor();
      int m, n, nn, u, sum, alpha, akk, w, t;
      longint acc, mg;
      m = dim(row_reg);
      n = dim(col_reg);
      if (m < n) return hqr_pkg::STATUS_SHAPE_ERR;
      for (int i = 0; i < m; i++)
         for (int j = 0; j < m; j++)
            q_word[i*8+j] = (i == j) ? 32'h0001_0000 : 0;
      nn = (m == n) ? m - 1 : n;
      for (int k = 0; k < nn; k++) begin
         u = 0;
         acc = 0;
         for (int i = k; i < m; i++) begin
            mg = magnitude(a_word[i*8+k]);
            if (mg > 64'sh7FFF_FFFF) mg = 64'sh7FFF_FFFF;
            if (int'(mg) > u) u = int'(mg);
         end
         for (int i = k; i < m; i++) begin
            t = qdiv(a_word[i*8+k], u);
            acc += qmul(t, t);
         end
         sum = clip(acc);
         akk = a_word[k*8+k];
         if (akk > 0) u = -u;
         alpha = clip(qmul(u, qsqrt(sum)));
         if (alpha == 0) return hqr_pkg::STATUS_NOT_DECOMP;
         w = qsqrt(clip(2 * qmul(alpha, clip(longint'(alpha) - akk))));
         if (w == 0) continue;
         a_word[k*8+k] = qdiv(clip(longint'(akk) - alpha), w);
         for (int i = k + 1; i < m; i++) a_word[i*8+k] = qdiv(a_word[i*8+k], w);
         for (int j = 0; j < m; j++) begin
            acc = 0;
            for (int jj = k; jj < m; jj++) acc += qmul(a_word[jj*8+k], q_word[j*8+jj]);
            t = clip(acc);
            for (int i = k; i < m; i++)
               q_word[j*8+i] = clip(longint'(q_word[j*8+i]) - 2 * qmul(t, a_word[i*8+k]));
         end
         for (int j = k + 1; j < n; j++) begin
            acc = 0;
            for (int jj = k; jj < m; jj++) acc += qmul(a_word[jj*8+k], a_word[jj*8+j]);
            t = clip(acc);
            for (int i = k; i < m; i++)
               a_word[i*8+j] = clip(longint'(a_word[i*8+j]) - 2 * qmul(t, a_word[i*8+k]));
         end
         a_word[k*8+k] = alpha;
         for (int i = k + 1; i < m; i++) a_word[i*8+k] = 0;
      end
      return hqr_pkg::STATUS_OK;
   endfunction

   function void set_register(logic idx, int v);
      if (idx == hqr_pkg::CSR_ROW_COUNT) row_reg = v;
      else col_reg = v;
   endfunction

   function void note_command(hqr_pkg::opcode_type op, int r, int c, int v);
      case (op)
         hqr_pkg::OP_WRITE: a_word[r*8+c] = v;
         hqr_pkg::OP_START: begin
            status = factor();
            expected_value.push_back(0);
            expected_status.push_back(status);
         end
         hqr_pkg::OP_READ_Q: begin
            expected_value.push_back(q_word[r*8+c]);
            expected_status.push_back(status);
         end
         default: begin
            expected_value.push_back(a_word[r*8+c]);
            expected_status.push_back(status);
         end
      endcase
   endfunction

   function void check_response(int v, logic [1:0] st);
      int ev;
      logic [1:0] es;
      if (expected_value.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response: value %h status %0d", v, st);
         return;
      end
      ev = expected_value.pop_front();
      es = expected_status.pop_front();
      if (ev !== v || es !== st) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     ev, es, v, st);
      end
   endfunction
endclass

module householder_qr_decomposition_unit_tb;

   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [hqr_pkg::OPCODE_W-1:0] req_opcode = '0;
   logic [hqr_pkg::INDEX_W-1:0] req_row = '0;
   logic [hqr_pkg::INDEX_W-1:0] req_col = '0;
   logic signed [hqr_pkg::WORD_W-1:0] req_value = '0;
   logic rsp_valid;
   logic signed [hqr_pkg::WORD_W-1:0] rsp_result_value;
   logic [hqr_pkg::STATUS_W-1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hqr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [hqr_pkg::DIM_REG_W-1:0] csr_wdata = '0;

   qr_scoreboard board = new();
   bit a_written [64];
   bit q_written [64];
   int idle_pct = 0;
   longint cycles = 0;

   householder_qr_decomposition_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("householder_qr_decomposition_unit_tb: errors");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_response(rsp_result_value, rsp_status);

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic issue(hqr_pkg::opcode_type op, int r, int c, int v);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_opcode = op;
      req_row = r[hqr_pkg::INDEX_W-1:0];
      req_col = c[hqr_pkg::INDEX_W-1:0];
      req_value = v;
      start = 1'b1;
      do @(posedge clock); while (busy);
      board.note_command(op, r, c, v);
      if (op == hqr_pkg::OP_WRITE) a_written[r*8+c] = 1'b1;
      if (op == hqr_pkg::OP_START && board.dim(board.row_reg) >= board.dim(board.col_reg))
         for (int i = 0; i < board.dim(board.row_reg); i++)
            for (int j = 0; j < board.dim(board.row_reg); j++) q_written[i*8+j] = 1'b1;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      while (board.expected_value.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_dims(int rows, int cols);
      int dimv;
      drain();
      for (int i = 0; i < 2; i++) begin
         csr_index = (i == 0) ? hqr_pkg::CSR_ROW_COUNT : hqr_pkg::CSR_COL_COUNT;
         dimv = (i == 0) ? rows : cols;
         csr_wdata = dimv[hqr_pkg::DIM_REG_W-1:0];
         csr_valid = 1'b1;
         do @(posedge clock); while (!csr_ready);
         board.set_register(csr_index, csr_wdata);
         @(negedge clock);
         csr_valid = 1'b0;
      end
   endtask

   function automatic int random_element();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return $urandom;
      if (pick == 1) return 0;
      return $signed($urandom_range(8 << 16)) - (4 << 16);
   endfunction

   task automatic read_any(output int sent);
      int r, c;
      bit use_q;
      sent = 0;
      use_q = $urandom_range(1) && q_written[0];
      repeat (40) begin
         r = $urandom_range(7);
         c = $urandom_range(7);
         if (use_q ? q_written[r*8+c] : a_written[r*8+c]) begin
            issue(use_q ? hqr_pkg::OP_READ_Q : hqr_pkg::OP_READ_R, r, c, 0);
            sent = 1;
            return;
         end
      end
   endtask

   // One load, factor and read-back round on the active shape.
   task automatic qr_round(output int sent);
      int m, n, got, zero_col;
      m = board.dim(board.row_reg);
      n = board.dim(board.col_reg);
      sent = 0;
      zero_col = ($urandom_range(9) == 0) ? $urandom_range(n - 1) : -1;
      for (int r = 0; r < m; r++)
         for (int c = 0; c < n; c++) begin
            issue(hqr_pkg::OP_WRITE, r, c, (c == zero_col) ? 0 : random_element());
            sent++;
         end
      if ($urandom_range(9) == 0) begin
         issue(hqr_pkg::OP_WRITE, $urandom_range(7), $urandom_range(7), $urandom);
         sent++;
      end
      issue(hqr_pkg::OP_START, $urandom_range(7), $urandom_range(7), $urandom);
      sent++;
      repeat ($urandom_range(3, 10)) begin
         read_any(got);
         sent += got;
      end
   endtask

   initial begin
      int sent, count, pct_list [4];
      int dims [9][2];
      dims = '{'{8, 8}, '{15, 2}, '{2, 1}, '{0, 0}, '{3, 5}, '{5, 3}, '{4, 4}, '{8, 1}, '{7, 7}};
      pct_list = '{0, 84, 0, 37};
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: extreme elements in an 8 by 8 load, then read back and factor.
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++)
            issue(hqr_pkg::OP_WRITE, r, c, (r == c) ? 32'h8000_0000 :
                  ((r + c) % 3 == 0) ? 32'h7FFF_FFFF : ((r * 8 + c) << 14) - 32'h0008_0000);
      issue(hqr_pkg::OP_READ_R, 7, 7, 0);
      issue(hqr_pkg::OP_READ_R, 0, 7, 32'hFFFF_FFFF);
      issue(hqr_pkg::OP_START, 0, 0, 0);
      issue(hqr_pkg::OP_READ_Q, 7, 0, 0);
      issue(hqr_pkg::OP_READ_R, 0, 0, 0);
      // A column whose reflection vanishes: a single tiny entry.
      write_dims(3, 1);
      issue(hqr_pkg::OP_WRITE, 0, 0, 1);
      issue(hqr_pkg::OP_WRITE, 1, 0, 0);
      issue(hqr_pkg::OP_WRITE, 2, 0, 0);
      issue(hqr_pkg::OP_START, 0, 0, 0);
      issue(hqr_pkg::OP_READ_R, 0, 0, 0);
      issue(hqr_pkg::OP_READ_Q, 2, 2, 0);
      // An all-zero first column cannot be decomposed.
      write_dims(3, 2);
      for (int r = 0; r < 3; r++) issue(hqr_pkg::OP_WRITE, r, 0, 0);
      issue(hqr_pkg::OP_START, 0, 0, 0);
      issue(hqr_pkg::OP_READ_R, 1, 1, 0);
      // Fewer rows than columns.
      write_dims(1, 8);
      issue(hqr_pkg::OP_START, 0, 0, 0);
      issue(hqr_pkg::OP_READ_Q, 1, 1, 0);

      for (int p = 0; p < 9; p++) begin
         write_dims(dims[p][0], dims[p][1]);
         idle_pct = pct_list[p % 4];
         count = 0;
         while (count < 30) begin
            qr_round(sent);
            count += sent;
         end
      end

      idle_pct = 0;
      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.expected_value.size() == 0) begin
         $display("householder_qr_decomposition_unit_tb: clean");
      end else begin
         $display("householder_qr_decomposition_unit_tb: errors");
      end
      $finish;
   end
endmodule
